@@ rtl/wswd_pkg.sv @@
// ----------------------------------------------------------------------------
// wswd_pkg
// shared types and constants for the wake score window detector
// ----------------------------------------------------------------------------
package wswd_pkg;

  localparam int SCORE_W     = 8;
  localparam int HOLD_W      = 10;
  localparam int SUM_W       = 12;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int WINDOW_LEN  = 5;

  localparam logic [SCORE_W-1:0] CUTOFF_RESET     = 8'd128;
  localparam logic [HOLD_W-1:0]  REFRACTORY_RESET = 10'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_CUTOFF       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_WINDOWS = 1'b1;

  // status handed from the hold-off counter to the top level
  typedef struct packed {
    logic armed;
  } hold_stat_t;

endpackage

@@ rtl/wswd_if.sv @@
// ----------------------------------------------------------------------------
// wswd channel interfaces
// valid/ready channels for score requests and detector results
// ----------------------------------------------------------------------------
interface wswd_in_if;
  logic                         valid;
  logic                         ready;
  logic [wswd_pkg::SCORE_W-1:0] score;

  modport source (output valid, output score, input ready);
  modport sink   (input valid, input score, output ready);
endinterface

interface wswd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       detected;
  logic                       armed;
  logic [wswd_pkg::SUM_W-1:0] window_sum;

  modport source (output valid, output detected, output armed, output window_sum,
                  input ready);
  modport sink   (input valid, input detected, input armed, input window_sum,
                  output ready);
endinterface

@@ rtl/wswd_cell.sv @@
// ----------------------------------------------------------------------------
// wswd_cell
// one score slot of the window shift line
// ----------------------------------------------------------------------------
module wswd_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift_en,
  input  logic                         clear,
  input  logic [wswd_pkg::SCORE_W-1:0] d,
  output logic [wswd_pkg::SCORE_W-1:0] q
);

  logic [wswd_pkg::SCORE_W-1:0] score_r;
  logic [wswd_pkg::SCORE_W-1:0] score_nxt;

  always_comb begin
    score_nxt = score_r;
    if (clear) begin
      score_nxt = '0;
    end else if (shift_en) begin
      score_nxt = d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else begin
      score_r <= score_nxt;
    end
  end

  assign q = score_r;

endmodule

@@ rtl/wswd_holdoff.sv @@
// ----------------------------------------------------------------------------
// wswd_holdoff
// hold-off counter: counts low scores down to zero, reloads on detection
// ----------------------------------------------------------------------------
module wswd_holdoff (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        below,
  input  logic                        reload,
  input  logic [wswd_pkg::HOLD_W-1:0] refractory,
  output wswd_pkg::hold_stat_t        stat
);

  logic [wswd_pkg::HOLD_W-1:0] left_r;
  logic [wswd_pkg::HOLD_W-1:0] left_nxt;
  logic [wswd_pkg::HOLD_W-1:0] left_dec;

  // count after this request's score, before any reload
  always_comb begin
    left_dec = left_r;
    if (below && (left_r != '0)) begin
      left_dec = left_r - wswd_pkg::HOLD_W'(1);
    end
    stat.armed = (left_dec == '0);
  end

  always_comb begin
    left_nxt = left_r;
    if (step) begin
      left_nxt = reload ? refractory : left_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= wswd_pkg::REFRACTORY_RESET;
    end else begin
      left_r <= left_nxt;
    end
  end

endmodule

@@ rtl/wake_score_window_detector_core.sv @@
// ----------------------------------------------------------------------------
// wake_score_window_detector_core
// sliding-window score threshold detector with hold-off counter
// ----------------------------------------------------------------------------
// result: registered, in the cycle after its score request is accepted
// throughput: one score per cycle, limited by the single running-sum adder
// the result sits in an output register; a new score is taken whenever that
// register is empty or is being drained in the same cycle
// reset (synchronous, rst_n low): window and running sum cleared, cutoff 128,
// refractory count 100, hold-off counter loaded with 100, no result pending
module wake_score_window_detector_core #(
  parameter int WINDOW_LEN = wswd_pkg::WINDOW_LEN
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  wswd_in_if.sink                               in_ch,
  wswd_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [wswd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wswd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int THR_W = wswd_pkg::SUM_W + 1;

  // configuration registers
  logic [wswd_pkg::SCORE_W-1:0] cutoff_r;
  logic [wswd_pkg::HOLD_W-1:0]  refractory_r;

  // window shift line taps
  logic [wswd_pkg::SCORE_W-1:0] cell_q [WINDOW_LEN];

  // running sum of the window, kept equal to the sum of all cells
  logic [wswd_pkg::SUM_W-1:0]   sum_r;
  logic [wswd_pkg::SUM_W-1:0]   sum_nxt;
  logic [wswd_pkg::SUM_W-1:0]   sum_new;

  // result register
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         detected_r;
  logic                         armed_r;
  logic [wswd_pkg::SUM_W-1:0]   window_sum_r;

  logic                         in_acc;
  logic                         below;
  logic                         detect;
  logic [THR_W-1:0]             threshold;
  wswd_pkg::hold_stat_t         hold_stat;

  // take a request when the result slot is free or drains this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r     <= wswd_pkg::CUTOFF_RESET;
      refractory_r <= wswd_pkg::REFRACTORY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wswd_pkg::CFG_SCORE_CUTOFF: begin
          cutoff_r <= cfg_data[wswd_pkg::SCORE_W-1:0];
        end
        wswd_pkg::CFG_REFRACTORY_WINDOWS: begin
          refractory_r <= cfg_data[wswd_pkg::HOLD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // window: a row of score cells, newest at cell 0, oldest at the end
  // the sum is order-free, so a shift line stands in for the ring buffer
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
    wswd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_acc),
      .clear    (detect),
      .d        ((gi == 0) ? in_ch.score : cell_q[(gi == 0) ? 0 : gi - 1]),
      .q        (cell_q[gi])
    );
  end

  // new score in, oldest score out
  assign sum_new = sum_r + wswd_pkg::SUM_W'(in_ch.score)
                 - wswd_pkg::SUM_W'(cell_q[WINDOW_LEN-1]);

  // ---------------------------------------------------------------------------
  // hold-off counter
  // ---------------------------------------------------------------------------
  assign below = (in_ch.score < cutoff_r);

  wswd_holdoff u_holdoff (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .below      (below),
    .reload     (detect),
    .refractory (refractory_r),
    .stat       (hold_stat)
  );

  // detection: while armed, window sum above cutoff times window length
  assign threshold = THR_W'(cutoff_r) * THR_W'(WINDOW_LEN);
  assign detect    = in_acc && hold_stat.armed
                  && ({1'b0, sum_new} > threshold);

  // detection clears the window, so the running sum restarts at zero
  always_comb begin
    sum_nxt = sum_r;
    if (detect) begin
      sum_nxt = '0;
    end else if (in_acc) begin
      sum_nxt = sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: held off shows all zeros
  always_ff @(posedge clk) begin
    if (in_acc) begin
      detected_r   <= detect;
      armed_r      <= hold_stat.armed;
      window_sum_r <= hold_stat.armed ? sum_new : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.detected   = detected_r;
  assign out_ch.armed      = armed_r;
  assign out_ch.window_sum = window_sum_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_clear_after_detect: assert property (@(posedge clk) disable iff (!rst_n)
    detect |=> (sum_r == '0) && (cell_q[0] == '0))
    else $error("window not cleared after detection");

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_ch.valid)
    else $error("accepted score gave no result");

  a_held_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.armed) |-> (!out_ch.detected && (out_ch.window_sum == '0)))
    else $error("held-off result is not all zeros");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wake_score_window_detector_core testbench
// streams detector scores through the core under several cutoff and hold-off
// settings and checks every result request against a cycle-free software
// model of the score ring, the hold-off counter and the window threshold
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BACKPRESSURE_CYCLES = 300;
  localparam int BACKPRESSURE_AFTER = 300;

  typedef struct packed {
    logic                       detected;
    logic                       armed;
    logic [wswd_pkg::SUM_W-1:0] window_sum;
  } detector_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [wswd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wswd_pkg::CFG_DATA_W-1:0] cfg_data;

  wswd_in_if  in_ch ();
  wswd_out_if out_ch ();

  wake_score_window_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scores waiting to be offered, and results the model says must come back
  logic [wswd_pkg::SCORE_W-1:0] pending_scores [$];
  detector_result_t             due_results [$];

  // software copy of the detector state and its two registers
  logic [wswd_pkg::SCORE_W-1:0] model_ring [wswd_pkg::WINDOW_LEN];
  logic [3:0]                   model_ptr;
  logic [wswd_pkg::HOLD_W-1:0]  model_holdoff;
  logic [wswd_pkg::SCORE_W-1:0] model_cutoff;
  logic [wswd_pkg::HOLD_W-1:0]  model_refractory;

  bit failed = 1'b0;
  int scores_accepted = 0;
  int cycle_count = 0;

  // sender burst shaping
  int burst_left = 0;
  int gap_left = 0;

  // receiver stall shaping
  int stall_mode = 0;
  int mode_left = 0;
  int backpressure_left = 0;
  bit backpressure_done = 1'b0;

  // one score through the window detector: store, count down, evaluate
  task automatic predict_window_step(input logic [wswd_pkg::SCORE_W-1:0] s);
    detector_result_t r;
    int unsigned total;
    r = '0;
    total = 0;
    model_ring[model_ptr] = s;
    model_ptr = (model_ptr == wswd_pkg::WINDOW_LEN - 1) ? 4'd0 : model_ptr + 4'd1;
    // only a score below the cutoff moves the counter, and it stops at zero
    if (s < model_cutoff && model_holdoff != 0)
      model_holdoff = model_holdoff - wswd_pkg::HOLD_W'(1);
    if (model_holdoff == 0) begin
      foreach (model_ring[i]) total += model_ring[i];
      r.armed = 1'b1;
      r.window_sum = total[wswd_pkg::SUM_W-1:0];
      // detection still reports the full sum; reload and clear show next step
      if (total > int'(model_cutoff) * wswd_pkg::WINDOW_LEN) begin
        r.detected = 1'b1;
        model_holdoff = model_refractory;
        foreach (model_ring[i]) model_ring[i] = '0;
      end
    end
    due_results.push_back(r);
  endtask

  // register write, only issued while the core is idle
  task automatic write_reg(input logic [wswd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wswd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    // upper data bits beyond the register width are dropped
    if (idx == wswd_pkg::CFG_SCORE_CUTOFF) model_cutoff = data[wswd_pkg::SCORE_W-1:0];
    else model_refractory = data[wswd_pkg::HOLD_W-1:0];
  endtask

  // sampled on the falling edge so the driver and monitor have settled
  task automatic wait_idle();
    while (pending_scores.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [wswd_pkg::SCORE_W-1:0] low_score();
    if (model_cutoff == 0) return wswd_pkg::SCORE_W'($urandom);
    return wswd_pkg::SCORE_W'($urandom_range(int'(model_cutoff) - 1, 0));
  endfunction

  function automatic logic [wswd_pkg::SCORE_W-1:0] high_score();
    return wswd_pkg::SCORE_W'($urandom_range(255, int'(model_cutoff)));
  endfunction

  // mostly well-formed wake sequences: a quiet run long enough to drain the
  // hold-off, then a burst of confident scores; the rest is noise or a
  // burst broken by a quiet score
  task automatic add_random_sequences(input int n);
    int added;
    int kind;
    int run;
    int burst;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(9, 0);
      if (kind < 7) begin
        run = int'(model_refractory) + $urandom_range(3, 0);
        if (run > 40) run = 40;
        burst = $urandom_range(wswd_pkg::WINDOW_LEN + 2, 1);
        repeat (run) pending_scores.push_back(low_score());
        repeat (burst) pending_scores.push_back(high_score());
        added += run + burst;
      end else if (kind < 9) begin
        run = $urandom_range(6, 1);
        repeat (run) pending_scores.push_back(wswd_pkg::SCORE_W'($urandom));
        added += run;
      end else begin
        pending_scores.push_back(high_score());
        pending_scores.push_back(high_score());
        pending_scores.push_back(low_score());
        pending_scores.push_back(high_score());
        pending_scores.push_back(high_score());
        added += 5;
      end
    end
  endtask

  // score request driver: bursts of random length with random gaps,
  // holding the payload steady while the core stalls
  always @(posedge clk) begin : drive_scores
    bit offer;
    logic [wswd_pkg::SCORE_W-1:0] next_score;
    offer = 1'b0;
    next_score = '0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_window_step(in_ch.score);
        scores_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_scores.size() != 0) begin
          offer = 1'b1;
          next_score = pending_scores.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            // a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left--;
          end
        end
        in_ch.valid <= offer;
        if (offer) in_ch.score <= next_score;
      end
    end
  end

  // one long receiver hold-off partway through, started while plenty of
  // scores are still queued, so the output register fills and the core
  // stalls its score requests
  always @(posedge clk) begin
    if (!rst_n) begin
      backpressure_left <= 0;
    end else if (!backpressure_done && scores_accepted >= BACKPRESSURE_AFTER
                 && pending_scores.size() > 16) begin
      backpressure_left <= BACKPRESSURE_CYCLES;
      backpressure_done <= 1'b1;
    end else if (backpressure_left != 0) begin
      backpressure_left <= backpressure_left - 1;
    end
  end

  // result monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    detector_result_t want;
    bit take;
    take = 1'b0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("result request with no score pending: detected=%0d armed=%0d sum=%0d",
                 out_ch.detected, out_ch.armed, out_ch.window_sum);
          failed = 1'b1;
        end else begin
          want = due_results.pop_front();
          if (out_ch.detected !== want.detected) begin
            $error("detected: expected %0d, got %0d", want.detected, out_ch.detected);
            failed = 1'b1;
          end
          if (out_ch.armed !== want.armed) begin
            $error("armed: expected %0d, got %0d", want.armed, out_ch.armed);
            failed = 1'b1;
          end
          if (out_ch.window_sum !== want.window_sum) begin
            $error("window_sum: expected %0d, got %0d", want.window_sum, out_ch.window_sum);
            failed = 1'b1;
          end
        end
      end
      // stall pattern: always ready, coin flip, one in four, mostly ready
      if (mode_left == 0) begin
        stall_mode = $urandom_range(3, 0);
        mode_left = $urandom_range(80, 20);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: take = 1'b1;
        1: take = $urandom_range(1, 0);
        2: take = (mode_left % 4 == 0);
        default: take = ($urandom_range(99, 0) < 85);
      endcase
      out_ch.ready <= take && (backpressure_left == 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("wake_score_window_detector_core regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [wswd_pkg::SCORE_W-1:0] cut;
    logic [wswd_pkg::HOLD_W-1:0] refr;
    // known values on every input from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.score = '0;
    out_ch.ready = 1'b0;
    // model starts in the reset state
    foreach (model_ring[i]) model_ring[i] = '0;
    model_ptr = '0;
    model_cutoff = wswd_pkg::CUTOFF_RESET;
    model_refractory = wswd_pkg::REFRACTORY_RESET;
    model_holdoff = wswd_pkg::REFRACTORY_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes and both sides of the cutoff while
    // held off, then quiet scores until the reset hold-off count runs out
    // (five quiet scores stay below the window threshold)
    pending_scores = '{8'd255, 8'd0, 8'd127, 8'd128, 8'd1, 8'd254, 8'hAA, 8'h55};
    repeat (100) pending_scores.push_back(low_score());
    wait_idle();

    // zero hold-off count, cutoff 128: a sum equal to the threshold does not
    // fire, one more point does, and the core re-arms right away
    write_reg(wswd_pkg::CFG_REFRACTORY_WINDOWS, 10'd0);
    repeat (wswd_pkg::WINDOW_LEN) pending_scores.push_back(8'd0);
    repeat (wswd_pkg::WINDOW_LEN) pending_scores.push_back(8'd128);
    pending_scores.push_back(8'd129);
    repeat (3) pending_scores.push_back(8'd255);
    wait_idle();

    // zero cutoff, written with junk in the upper data bits: any nonzero
    // window fires
    write_reg(wswd_pkg::CFG_SCORE_CUTOFF, 10'h300);
    repeat (wswd_pkg::WINDOW_LEN) pending_scores.push_back(8'd0);
    pending_scores.push_back(8'd1);
    pending_scores.push_back(8'd0);
    add_random_sequences(40);
    wait_idle();

    // random settings, starting with the top cutoff (no window can pass it)
    // and the lowest nonzero one; hold-off counts stay short so detections
    // keep coming
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin cut = 8'd255; refr = 10'd3; end
        1: begin cut = 8'd1;   refr = 10'd2; end
        default: begin
          cut = wswd_pkg::SCORE_W'($urandom_range(254, 20));
          refr = wswd_pkg::HOLD_W'($urandom_range(12, 0));
        end
      endcase
      write_reg(wswd_pkg::CFG_SCORE_CUTOFF, {2'($urandom), cut});
      write_reg(wswd_pkg::CFG_REFRACTORY_WINDOWS, refr);
      add_random_sequences(85);
      wait_idle();
    end

    // full hold-off count: one detection loads it and the core goes quiet
    write_reg(wswd_pkg::CFG_REFRACTORY_WINDOWS, 10'd1023);
    write_reg(wswd_pkg::CFG_SCORE_CUTOFF, 10'd200);
    repeat (15) pending_scores.push_back(low_score());
    repeat (wswd_pkg::WINDOW_LEN) pending_scores.push_back(8'd255);
    repeat (20) pending_scores.push_back(wswd_pkg::SCORE_W'($urandom));
    wait_idle();

    // zero cutoff while held off: the counter never moves
    write_reg(wswd_pkg::CFG_SCORE_CUTOFF, 10'd0);
    repeat (20) pending_scores.push_back(wswd_pkg::SCORE_W'($urandom));
    wait_idle();
    repeat (4) @(posedge clk);

    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("wake_score_window_detector_core regression: pass");
    end else begin
      $display("wake_score_window_detector_core regression: fail");
    end
    $finish;
  end

endmodule
